/* hw/rtl/aphp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aphp_pkg
// Shared types and codes for the APV access-unit header probe.
// ----------------------------------------------------------------------------
package aphp_pkg;

    localparam int DEF_MAX_DIMENSION    = 65536;
    localparam int DEF_MIN_BUFFER_BYTES = 28;

    localparam logic [31:0] SIG_RESET = 32'h6150_7631;  // "aPv1"

    // fail causes
    localparam logic [2:0] CAUSE_OK      = 3'd0;
    localparam logic [2:0] CAUSE_SHORT   = 3'd1;
    localparam logic [2:0] CAUSE_AU_SIZE = 3'd2;
    localparam logic [2:0] CAUSE_SIG     = 3'd3;
    localparam logic [2:0] CAUSE_PBU_SZ  = 3'd4;
    localparam logic [2:0] CAUSE_PBU_TY  = 3'd5;
    localparam logic [2:0] CAUSE_ZERO    = 3'd6;
    localparam logic [2:0] CAUSE_DIM     = 3'd7;

    // PBU types
    localparam logic [7:0] PBU_PRIMARY     = 8'd1;
    localparam logic [7:0] PBU_NON_PRIMARY = 8'd2;
    localparam logic [7:0] PBU_PREVIEW     = 8'd25;
    localparam logic [7:0] PBU_ALPHA       = 8'd27;
    localparam logic [7:0] PBU_AU_INFO     = 8'd65;

    localparam logic [31:0] AU_SIZE_MIN  = 32'd24;
    localparam logic [31:0] PBU_SIZE_MIN = 32'd16;
    localparam logic [3:0]  DEPTH_MAX    = 4'd8;

    // byte positions
    localparam logic [5:0] POS_AU_SIZE   = 6'd3;
    localparam logic [5:0] POS_SIG       = 6'd7;
    localparam logic [5:0] POS_PBU_SIZE  = 6'd11;
    localparam logic [5:0] POS_PBU_TYPE  = 6'd12;
    localparam logic [5:0] POS_HDR_ZERO  = 6'd15;
    localparam logic [5:0] POS_BODY      = 6'd16;
    localparam logic [5:0] POS_NFRAMES   = 6'd17;
    localparam logic [5:0] POS_INNER_TY  = 6'd18;
    localparam logic [5:0] POS_INFO_ZERO = 6'd21;
    localparam logic [5:0] POS_SAT       = 6'd63;

    localparam logic [5:0] BASE_PLAIN   = 6'd16;
    localparam logic [5:0] BASE_WRAPPED = 6'd22;

    // offsets from frame-info base
    localparam logic [5:0] REL_PROFILE = 6'd0;
    localparam logic [5:0] REL_LEVEL   = 6'd1;
    localparam logic [5:0] REL_BAND    = 6'd2;
    localparam logic [5:0] REL_WIDTH   = 6'd5;
    localparam logic [5:0] REL_HEIGHT  = 6'd8;
    localparam logic [5:0] REL_DEPTH   = 6'd9;
    localparam logic [5:0] REL_ZERO    = 6'd11;

    // buffer length needed to hold the last height byte
    localparam logic [6:0] LEN_HEIGHT_PLAIN   = 7'({1'b0, BASE_PLAIN} + 7'd9);
    localparam logic [6:0] LEN_HEIGHT_WRAPPED = 7'({1'b0, BASE_WRAPPED} + 7'd9);

    typedef struct packed {
        logic        accepted;
        logic [2:0]  fail_cause;
        logic [7:0]  profile_code;
        logic [7:0]  level_code;
        logic [4:0]  band_code;
        logic [16:0] width_px;
        logic [16:0] height_px;
        logic [3:0]  depth_code;
    } verdict_t;

endpackage

/* hw/rtl/aphp_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aphp_in_stage
// Input register for one buffer byte and its last marker.
// ----------------------------------------------------------------------------
module aphp_in_stage import aphp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_byte,
    output logic       in_last
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // take a new byte when the register is empty or the held one moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            byte_reg <= s_data_byte;
            last_reg <= s_last_byte;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;
    assign in_last  = last_reg;

endmodule

/* hw/rtl/aphp_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aphp_parser
// Per-byte header state: position, field accumulator, captures and the
// first failure. Forms the verdict on the last byte and clears for the next.
// ----------------------------------------------------------------------------
module aphp_parser import aphp_pkg::*; #(
    parameter int MAX_DIMENSION    = DEF_MAX_DIMENSION,
    parameter int MIN_BUFFER_BYTES = DEF_MIN_BUFFER_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic [31:0] signature,
    output verdict_t    verdict
);

    localparam logic [23:0] MAX_DIM = 24'(MAX_DIMENSION);
    localparam logic [6:0]  MIN_LEN = 7'(MIN_BUFFER_BYTES);

    logic [5:0]  pos_reg,     pos_next;
    logic        wrapped_reg, wrapped_next;
    logic [2:0]  failed_reg,  failed_next;
    logic [31:0] acc_reg,     acc_next;
    logic [7:0]  profile_reg, profile_next;
    logic [7:0]  level_reg,   level_next;
    logic [4:0]  band_reg,    band_next;
    logic [23:0] width_reg,   width_next;
    logic [23:0] height_reg,  height_next;
    logic [3:0]  depth_reg,   depth_next;

    logic [31:0] acc_shift;
    logic [5:0]  rel;
    logic        frame_en;
    logic        inner_ok;
    logic [6:0]  length;
    logic        short_buf;
    logic [2:0]  cause;

    function automatic logic dim_ok(input logic [23:0] v);
        return (v != 24'd0) && (v <= MAX_DIM);
    endfunction

    assign acc_shift = {acc_reg[23:0], in_byte};
    assign rel       = pos_reg - (wrapped_reg ? BASE_WRAPPED : BASE_PLAIN);
    assign inner_ok  = (in_byte == PBU_PRIMARY) || (in_byte == PBU_NON_PRIMARY) ||
                       ((in_byte >= PBU_PREVIEW) && (in_byte <= PBU_ALPHA));

    always_comb begin
        pos_next     = (pos_reg != POS_SAT) ? pos_reg + 6'd1 : pos_reg;
        wrapped_next = wrapped_reg;
        failed_next  = failed_reg;
        acc_next     = acc_reg;
        profile_next = profile_reg;
        level_next   = level_reg;
        band_next    = band_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        depth_next   = depth_reg;
        frame_en     = 1'b0;

        // nothing is examined after a failure or once the position saturates
        if ((failed_reg == CAUSE_OK) && (pos_reg != POS_SAT)) begin
            acc_next = acc_shift;
            case (pos_reg)
                POS_AU_SIZE: begin
                    if (acc_shift < AU_SIZE_MIN) failed_next = CAUSE_AU_SIZE;
                end
                POS_SIG: begin
                    if (acc_shift != signature) failed_next = CAUSE_SIG;
                end
                POS_PBU_SIZE: begin
                    if (acc_shift < PBU_SIZE_MIN) failed_next = CAUSE_PBU_SZ;
                end
                POS_PBU_TYPE: begin
                    if (in_byte == PBU_AU_INFO) begin
                        wrapped_next = 1'b1;
                    end else if (in_byte != PBU_PRIMARY) begin
                        failed_next = CAUSE_PBU_TY;
                    end
                end
                POS_HDR_ZERO: begin
                    if (in_byte != 8'd0) failed_next = CAUSE_ZERO;
                end
                default: begin
                    if (pos_reg >= POS_BODY) begin
                        if (wrapped_reg) begin
                            if (pos_reg == POS_NFRAMES) begin
                                if (acc_shift[15:0] == 16'd0) failed_next = CAUSE_PBU_TY;
                            end else if (pos_reg == POS_INNER_TY) begin
                                if (!inner_ok) failed_next = CAUSE_PBU_TY;
                            end else if (pos_reg == POS_INFO_ZERO) begin
                                if (in_byte != 8'd0) failed_next = CAUSE_ZERO;
                            end else if (pos_reg >= BASE_WRAPPED) begin
                                frame_en = 1'b1;
                            end
                        end else begin
                            frame_en = 1'b1;
                        end
                    end
                end
            endcase

            if (frame_en) begin
                case (rel)
                    REL_PROFILE: profile_next = in_byte;
                    REL_LEVEL:   level_next   = in_byte;
                    REL_BAND: begin
                        band_next = in_byte[7:3];
                        if (in_byte[2:0] != 3'd0) failed_next = CAUSE_ZERO;
                    end
                    REL_WIDTH:   width_next   = acc_shift[23:0];
                    REL_HEIGHT: begin
                        height_next = acc_shift[23:0];
                        if (!dim_ok(width_reg) || !dim_ok(acc_shift[23:0])) begin
                            failed_next = CAUSE_DIM;
                        end
                    end
                    REL_DEPTH: begin
                        depth_next = in_byte[3:0];
                        if ((in_byte[3:0] > DEPTH_MAX) || in_byte[0]) failed_next = CAUSE_DIM;
                    end
                    REL_ZERO: begin
                        if (in_byte != 8'd0) failed_next = CAUSE_ZERO;
                    end
                    default: ;
                endcase
            end
        end
    end

    // verdict from the state as it stands after this byte
    always_comb begin
        length    = {1'b0, pos_reg} + 7'd1;
        short_buf = length < MIN_LEN;
        cause     = failed_next;
        // a height cut off by the end of the buffer reads as zero
        if ((cause == CAUSE_OK) &&
            (length < (wrapped_next ? LEN_HEIGHT_WRAPPED : LEN_HEIGHT_PLAIN))) begin
            cause = CAUSE_DIM;
        end
        if (short_buf) cause = CAUSE_SHORT;

        verdict.accepted     = (cause == CAUSE_OK);
        verdict.fail_cause   = cause;
        verdict.profile_code = short_buf ? 8'd0  : profile_next;
        verdict.level_code   = short_buf ? 8'd0  : level_next;
        verdict.band_code    = short_buf ? 5'd0  : band_next;
        verdict.width_px     = short_buf ? 17'd0 : width_next[16:0];
        verdict.height_px    = short_buf ? 17'd0 : height_next[16:0];
        verdict.depth_code   = short_buf ? 4'd0  : depth_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_last)) begin
            pos_reg     <= 6'd0;
            wrapped_reg <= 1'b0;
            failed_reg  <= CAUSE_OK;
            acc_reg     <= 32'd0;
            profile_reg <= 8'd0;
            level_reg   <= 8'd0;
            band_reg    <= 5'd0;
            width_reg   <= 24'd0;
            height_reg  <= 24'd0;
            depth_reg   <= 4'd0;
        end else if (advance) begin
            pos_reg     <= pos_next;
            wrapped_reg <= wrapped_next;
            failed_reg  <= failed_next;
            acc_reg     <= acc_next;
            profile_reg <= profile_next;
            level_reg   <= level_next;
            band_reg    <= band_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            depth_reg   <= depth_next;
        end
    end

endmodule

/* hw/rtl/aphp_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aphp_out_stage
// Result register holding one verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module aphp_out_stage import aphp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  verdict_t verdict,
    input  logic     m_ready,
    output logic     m_valid,
    output logic     free,
    output verdict_t result
);

    logic     valid_reg;
    verdict_t result_reg;

    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= verdict;
        end
    end

    assign m_valid = valid_reg;
    assign result  = result_reg;

endmodule

/* hw/rtl/apv_header_probe_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apv_header_probe_top
// APV access-unit header probe: one verdict per probe buffer.
// ----------------------------------------------------------------------------
// Bytes of a probe buffer arrive on the s_ channel, one per transfer, with
// s_last_byte marking the final byte. Each buffer yields one result transfer
// on the m_ channel: accept flag, fail cause and the captured header fields.
// The cfg channel writes the expected 32-bit signature; cfg_ready is always
// high and a write is meant to happen only while no buffer is in flight.
// Throughput: one byte per cycle, while no last byte waits on a full result
// register. Each byte passes an input register, then one pass of position/field
// logic that updates the header state and, on the last byte, loads the result
// register. After the last byte's transfer the byte lands in the input
// register, and the result register loads its verdict once it is free.
// When the receiver stalls, a waiting last byte stays in the input register
// and s_ready drops until the result register frees up; other bytes keep
// flowing. Reset clears the pipeline valids and the header state and sets the
// signature to "aPv1"; no result is pending after reset.
// ----------------------------------------------------------------------------
module apv_header_probe_top import aphp_pkg::*; #(
    parameter int MAX_DIMENSION    = DEF_MAX_DIMENSION,
    parameter int MIN_BUFFER_BYTES = DEF_MIN_BUFFER_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [2:0]  m_fail_cause,
    output logic [7:0]  m_profile_code,
    output logic [7:0]  m_level_code,
    output logic [4:0]  m_band_code,
    output logic [16:0] m_width_px,
    output logic [16:0] m_height_px,
    output logic [3:0]  m_depth_code
);

    logic [31:0] sig_reg;
    logic        in_valid;
    logic [7:0]  in_byte;
    logic        in_last;
    logic        advance;
    logic        out_free;
    verdict_t    verdict;
    verdict_t    result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_reg <= SIG_RESET;
        end else if (cfg_valid) begin
            sig_reg <= cfg_data;
        end
    end

    // a last byte moves on only when the result register can take its verdict
    assign advance = in_valid && (!in_last || out_free);

    aphp_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .advance     (advance),
        .in_valid    (in_valid),
        .in_byte     (in_byte),
        .in_last     (in_last)
    );

    aphp_parser #(
        .MAX_DIMENSION    (MAX_DIMENSION),
        .MIN_BUFFER_BYTES (MIN_BUFFER_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .signature (sig_reg),
        .verdict   (verdict)
    );

    aphp_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && in_last),
        .verdict (verdict),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .free    (out_free),
        .result  (result)
    );

    assign m_accepted     = result.accepted;
    assign m_fail_cause   = result.fail_cause;
    assign m_profile_code = result.profile_code;
    assign m_level_code   = result.level_code;
    assign m_band_code    = result.band_code;
    assign m_width_px     = result.width_px;
    assign m_height_px    = result.height_px;
    assign m_depth_code   = result.depth_code;

endmodule

/* hw/rtl/aphp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aphp_checker
// Port-level checks on the probe's results, bound to the top level.
// ----------------------------------------------------------------------------
module aphp_checker import aphp_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_accepted,
    input logic [2:0]  m_fail_cause,
    input logic [7:0]  m_profile_code,
    input logic [7:0]  m_level_code,
    input logic [4:0]  m_band_code,
    input logic [16:0] m_width_px,
    input logic [16:0] m_height_px,
    input logic [3:0]  m_depth_code
);

    // a stalled result stays valid and keeps its fail cause and width
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fail_cause) && $stable(m_width_px))
        else $error("result changed while stalled");

    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_accepted == (m_fail_cause == CAUSE_OK)))
        else $error("accept flag disagrees with fail cause");

    a_short: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_fail_cause == CAUSE_SHORT) |->
            (m_profile_code == 8'd0) && (m_level_code == 8'd0) && (m_band_code == 5'd0) &&
            (m_width_px == 17'd0) && (m_height_px == 17'd0) && (m_depth_code == 4'd0))
        else $error("short buffer reported nonzero fields");

    a_good: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |->
            (m_width_px != 17'd0) && (m_height_px != 17'd0) &&
            !m_depth_code[0] && (m_depth_code <= DEPTH_MAX))
        else $error("accepted header with bad dimensions or depth");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind apv_header_probe_top aphp_checker u_aphp_checker (.*);

/* sim/tb_apv_header_probe_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_apv_header_probe_top
// Self-checking bench for the APV access-unit header probe.
// ----------------------------------------------------------------------------
// Probe buffers go in as byte transfers on the s_ channel. A behavioral
// predictor follows every accepted byte and queues the verdict that the last
// byte of each buffer should produce. Every m_ transfer is checked against
// the oldest queued verdict. Stimulus starts with a directed set: clean plain
// header, one buffer per failure kind, short, cut-off and long
// buffers. It then runs random phases of mostly well-formed headers with
// random content, single-field defects, cut-off buffers and noise. Each
// phase sets its own signature and its own mix of source gaps and sink
// stalls.
// ----------------------------------------------------------------------------
module tb_apv_header_probe_top;
    import aphp_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_AU_SIZE,
        FLAW_SIG,
        FLAW_PBU_SIZE,
        FLAW_PBU_TYPE,
        FLAW_HDR_ZERO,
        FLAW_NO_FRAMES,
        FLAW_INNER_TYPE,
        FLAW_INFO_ZERO,
        FLAW_BAND_BITS,
        FLAW_WIDTH,
        FLAW_HEIGHT,
        FLAW_DEPTH,
        FLAW_TAIL_ZERO,
        FLAW_NOISE
    } flaw_e;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_accepted;
    logic [2:0]  m_fail_cause;
    logic [7:0]  m_profile_code;
    logic [7:0]  m_level_code;
    logic [4:0]  m_band_code;
    logic [16:0] m_width_px;
    logic [16:0] m_height_px;
    logic [3:0]  m_depth_code;

    apv_header_probe_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_accepted     (m_accepted),
        .m_fail_cause   (m_fail_cause),
        .m_profile_code (m_profile_code),
        .m_level_code   (m_level_code),
        .m_band_code    (m_band_code),
        .m_width_px     (m_width_px),
        .m_height_px    (m_height_px),
        .m_depth_code   (m_depth_code)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // stimulus side
    byte_item_t  send_q[$];
    logic [7:0]  probe_bytes [0:79];
    logic [31:0] stim_sig = SIG_RESET;
    int          bytes_queued = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    bit          byte_taken = 1'b0;

    // predictor state
    logic [31:0] sig_reg = SIG_RESET;
    int unsigned probe_pos = 0;
    logic        probe_wrapped = 1'b0;
    logic [2:0]  probe_cause = CAUSE_OK;
    logic [31:0] shift_word = '0;
    logic [7:0]  seen_profile = '0;
    logic [7:0]  seen_level = '0;
    logic [4:0]  seen_band = '0;
    logic [23:0] seen_width = '0;
    logic [23:0] seen_height = '0;
    logic [3:0]  seen_depth = '0;
    verdict_t    pending_verdicts[$];
    int          fail_count = 0;

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] ERROR: %s", $time, what);
    endtask

    function automatic string verdict_str(input verdict_t v);
        return $sformatf("acc=%0b cause=%0d prof=%02h lvl=%02h band=%02h w=%05h h=%05h dep=%0h",
                         v.accepted, v.fail_cause, v.profile_code, v.level_code,
                         v.band_code, v.width_px, v.height_px, v.depth_code);
    endfunction

    // frame-info bytes, rel counted from the frame-info base
    task automatic frame_field(input int unsigned rel, input logic [7:0] b);
        case (rel)
            REL_PROFILE: seen_profile = b;
            REL_LEVEL:   seen_level = b;
            REL_BAND: begin
                seen_band = b[7:3];
                if (b[2:0] != 3'd0)
                    probe_cause = CAUSE_ZERO;
            end
            REL_WIDTH:   seen_width = shift_word[23:0];
            REL_HEIGHT: begin
                seen_height = shift_word[23:0];
                if (seen_width < 1 || seen_width > DEF_MAX_DIMENSION ||
                    seen_height < 1 || seen_height > DEF_MAX_DIMENSION)
                    probe_cause = CAUSE_DIM;
            end
            REL_DEPTH: begin
                seen_depth = b[3:0];
                if (seen_depth > DEPTH_MAX || seen_depth[0])
                    probe_cause = CAUSE_DIM;
            end
            REL_ZERO: if (b != 8'd0) probe_cause = CAUSE_ZERO;
            default: ;
        endcase
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        int unsigned at;
        int unsigned base;
        int unsigned len;
        logic [2:0]  cause;
        logic        short_buf;
        verdict_t    v;
        at = probe_pos;
        if (probe_cause == CAUSE_OK && at < POS_SAT) begin
            shift_word = {shift_word[23:0], b};
            case (at)
                POS_AU_SIZE:  if (shift_word < AU_SIZE_MIN) probe_cause = CAUSE_AU_SIZE;
                POS_SIG:      if (shift_word != sig_reg) probe_cause = CAUSE_SIG;
                POS_PBU_SIZE: if (shift_word < PBU_SIZE_MIN) probe_cause = CAUSE_PBU_SZ;
                POS_PBU_TYPE: begin
                    if (b == PBU_AU_INFO)
                        probe_wrapped = 1'b1;
                    else if (b != PBU_PRIMARY)
                        probe_cause = CAUSE_PBU_TY;
                end
                POS_HDR_ZERO: if (b != 8'd0) probe_cause = CAUSE_ZERO;
                default: begin
                    if (at >= POS_BODY) begin
                        if (!probe_wrapped) begin
                            frame_field(at - BASE_PLAIN, b);
                        end else if (at == POS_NFRAMES) begin
                            if (shift_word[15:0] == 16'd0)
                                probe_cause = CAUSE_PBU_TY;
                        end else if (at == POS_INNER_TY) begin
                            if (!(b == PBU_PRIMARY || b == PBU_NON_PRIMARY ||
                                  (b >= PBU_PREVIEW && b <= PBU_ALPHA)))
                                probe_cause = CAUSE_PBU_TY;
                        end else if (at == POS_INFO_ZERO) begin
                            if (b != 8'd0)
                                probe_cause = CAUSE_ZERO;
                        end else if (at >= BASE_WRAPPED) begin
                            frame_field(at - BASE_WRAPPED, b);
                        end
                    end
                end
            endcase
        end
        if (probe_pos < POS_SAT)
            probe_pos++;
        if (last) begin
            len = at + 1;
            short_buf = (len < DEF_MIN_BUFFER_BYTES);
            cause = probe_cause;
            base = probe_wrapped ? BASE_WRAPPED : BASE_PLAIN;
            // height bytes missing read as zero height
            if (cause == CAUSE_OK && len < base + REL_HEIGHT + 1)
                cause = CAUSE_DIM;
            if (short_buf)
                cause = CAUSE_SHORT;
            v.accepted     = (cause == CAUSE_OK);
            v.fail_cause   = cause;
            v.profile_code = short_buf ? 8'd0 : seen_profile;
            v.level_code   = short_buf ? 8'd0 : seen_level;
            v.band_code    = short_buf ? 5'd0 : seen_band;
            v.width_px     = short_buf ? 17'd0 : seen_width[16:0];
            v.height_px    = short_buf ? 17'd0 : seen_height[16:0];
            v.depth_code   = short_buf ? 4'd0 : seen_depth;
            pending_verdicts.push_back(v);
            probe_pos     = 0;
            probe_wrapped = 1'b0;
            probe_cause   = CAUSE_OK;
            shift_word    = '0;
            seen_profile  = '0;
            seen_level    = '0;
            seen_band     = '0;
            seen_width    = '0;
            seen_height   = '0;
            seen_depth    = '0;
        end
    endtask

    task automatic put_be(input int at, input int nbytes, input logic [31:0] w);
        for (int i = 0; i < nbytes; i++)
            probe_bytes[at + i] = w[8 * (nbytes - 1 - i) +: 8];
    endtask

    function automatic logic [23:0] legal_dim();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 24'd1;
        if (r == 1)
            return 24'(DEF_MAX_DIMENSION);
        return 24'($urandom_range(1, DEF_MAX_DIMENSION));
    endfunction

    // Builds one probe buffer and queues its bytes. keep > 0 cuts the buffer
    // short of the full header, extra appends junk after it.
    task automatic add_buffer(input flaw_e flaw, input bit wrap, input int keep,
                              input int extra);
        int          base;
        int          natural;
        int          n;
        logic [31:0] word;
        logic [23:0] bad_dim;
        logic [7:0]  b;
        logic [3:0]  d;
        byte_item_t  item;
        for (int i = 0; i < 80; i++)
            probe_bytes[i] = 8'($urandom_range(0, 255));
        if (flaw inside {FLAW_NO_FRAMES, FLAW_INNER_TYPE, FLAW_INFO_ZERO})
            wrap = 1'b1;
        base = wrap ? BASE_WRAPPED : BASE_PLAIN;
        natural = base + REL_ZERO + 1;
        if (flaw == FLAW_NOISE) begin
            natural = $urandom_range(1, 40);
        end else begin
            word = $urandom();
            if (word < AU_SIZE_MIN || $urandom_range(0, 7) == 0)
                word = AU_SIZE_MIN;
            put_be(0, 4, word);
            put_be(4, 4, stim_sig);
            word = $urandom();
            if (word < PBU_SIZE_MIN || $urandom_range(0, 7) == 0)
                word = PBU_SIZE_MIN;
            put_be(8, 4, word);
            probe_bytes[POS_PBU_TYPE] = wrap ? PBU_AU_INFO : PBU_PRIMARY;
            probe_bytes[POS_HDR_ZERO] = 8'd0;
            if (wrap) begin
                put_be(POS_BODY, 2, $urandom_range(1, 16'hFFFF));
                case ($urandom_range(0, 4))
                    0:       b = PBU_PRIMARY;
                    1:       b = PBU_NON_PRIMARY;
                    default: b = PBU_PREVIEW + 8'($urandom_range(0, 2));
                endcase
                probe_bytes[POS_INNER_TY] = b;
                probe_bytes[POS_INFO_ZERO] = 8'd0;
            end
            probe_bytes[base + REL_BAND][2:0] = 3'd0;
            put_be(base + REL_WIDTH - 2, 3, legal_dim());
            put_be(base + REL_HEIGHT - 2, 3, legal_dim());
            probe_bytes[base + REL_DEPTH][3:0] = 4'(2 * $urandom_range(0, 4));
            probe_bytes[base + REL_ZERO] = 8'd0;

            bad_dim = $urandom_range(0, 1) ? 24'd0
                                           : 24'($urandom_range(DEF_MAX_DIMENSION + 1, 24'hFFFFFF));
            case (flaw)
                FLAW_AU_SIZE:  put_be(0, 4, $urandom_range(0, AU_SIZE_MIN - 1));
                FLAW_SIG: begin
                    word = $urandom();
                    if (word == 32'd0)
                        word = 32'd1;
                    put_be(4, 4, stim_sig ^ word);
                end
                FLAW_PBU_SIZE: put_be(8, 4, $urandom_range(0, PBU_SIZE_MIN - 1));
                FLAW_PBU_TYPE: begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == PBU_PRIMARY || b == PBU_AU_INFO);
                    probe_bytes[POS_PBU_TYPE] = b;
                end
                FLAW_HDR_ZERO:   probe_bytes[POS_HDR_ZERO] = 8'($urandom_range(1, 255));
                FLAW_NO_FRAMES:  put_be(POS_BODY, 2, 32'd0);
                FLAW_INNER_TYPE: begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == PBU_PRIMARY || b == PBU_NON_PRIMARY ||
                           (b >= PBU_PREVIEW && b <= PBU_ALPHA));
                    probe_bytes[POS_INNER_TY] = b;
                end
                FLAW_INFO_ZERO: probe_bytes[POS_INFO_ZERO] = 8'($urandom_range(1, 255));
                FLAW_BAND_BITS: probe_bytes[base + REL_BAND][2:0] = 3'($urandom_range(1, 7));
                FLAW_WIDTH:     put_be(base + REL_WIDTH - 2, 3, bad_dim);
                FLAW_HEIGHT:    put_be(base + REL_HEIGHT - 2, 3, bad_dim);
                FLAW_DEPTH: begin
                    do d = 4'($urandom_range(0, 15));
                    while (!(d > DEPTH_MAX || d[0]));
                    probe_bytes[base + REL_DEPTH][3:0] = d;
                end
                FLAW_TAIL_ZERO: probe_bytes[base + REL_ZERO] = 8'($urandom_range(1, 255));
                default: ;
            endcase
        end
        n = (keep > 0 && keep < natural) ? keep : natural + extra;
        if (n > 80)
            n = 80;
        for (int i = 0; i < n; i++) begin
            item.data = probe_bytes[i];
            item.last = (i == n - 1);
            send_q.push_back(item);
        end
        bytes_queued += n;
    endtask

    task automatic write_signature(input logic [31:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        stim_sig = value;
    endtask

    // wait until all bytes went out and every verdict came back
    task automatic drain_and_check();
        int guard;
        guard = 0;
        while ((send_q.size() != 0 || s_valid || pending_verdicts.size() != 0) &&
               guard < 50000) begin
            @(posedge aclk);
            guard++;
        end
        // the last result passes the input and result registers; idle before the final check
        repeat (8) @(posedge aclk);
        if (pending_verdicts.size() != 0) begin
            note_failure($sformatf("%0d verdicts never arrived, oldest %s",
                                   pending_verdicts.size(),
                                   verdict_str(pending_verdicts[0])));
            pending_verdicts.delete();
        end
    endtask

    // byte driver and sink ready
    always @(negedge aclk) begin
        byte_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || byte_taken) begin
            if (send_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                nxt = send_q.pop_front();
                s_valid     <= 1'b1;
                s_data_byte <= nxt.data;
                s_last_byte <= nxt.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // monitor: tracks cfg and byte transfers, checks result transfers
    always @(posedge aclk) begin
        verdict_t got;
        verdict_t want;
        byte_taken = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sig_reg = cfg_data;
            if (s_valid && s_ready) begin
                byte_taken = 1'b1;
                absorb_byte(s_data_byte, s_last_byte);
            end
            if (m_valid && m_ready) begin
                got = {m_accepted, m_fail_cause, m_profile_code, m_level_code,
                       m_band_code, m_width_px, m_height_px, m_depth_code};
                if (pending_verdicts.size() == 0) begin
                    note_failure($sformatf("unexpected result %s", verdict_str(got)));
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got !== want)
                        note_failure($sformatf("verdict mismatch\n  exp %s\n  got %s",
                                               verdict_str(want), verdict_str(got)));
                end
            end
        end
    end

    initial begin
        int  phase_start;
        int  r;
        bit  wrap;
        flaw_e flaw;
        logic [31:0] sig;

        // directed set, default signature
        for (int f = FLAW_NONE; f <= FLAW_NOISE; f++)
            add_buffer(flaw_e'(f), f[0], 0, 0);
        add_buffer(FLAW_NONE, 1'b0, 1, 0);      // one byte, short
        add_buffer(FLAW_NONE, 1'b0, 27, 0);     // one byte under the minimum
        add_buffer(FLAW_AU_SIZE, 1'b0, 10, 0);  // short wins over bad size
        add_buffer(FLAW_NONE, 1'b1, 30, 0);     // wrapped, height cut off
        add_buffer(FLAW_NONE, 1'b1, 31, 0);     // wrapped, depth missing
        add_buffer(FLAW_NONE, 1'b0, 0, 45);     // long, position saturates

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        drain_and_check();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       sig = 32'h0000_0000;
                1:       sig = 32'hFFFF_FFFF;
                7:       sig = SIG_RESET;
                default: sig = $urandom();
            endcase
            write_signature(sig);
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 80; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 80; end
                default: begin src_idle_pct = 6; sink_stall_pct = 6; end
            endcase
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < 125) begin
                r = $urandom_range(0, 99);
                wrap = 1'($urandom_range(0, 1));
                if (r < 55)
                    flaw = FLAW_NONE;
                else if (r < 88)
                    flaw = flaw_e'($urandom_range(FLAW_AU_SIZE, FLAW_TAIL_ZERO));
                else
                    flaw = FLAW_NOISE;
                r = $urandom_range(0, 99);
                if (r < 70)
                    add_buffer(flaw, wrap, 0, $urandom_range(0, 3));
                else if (r < 92)
                    add_buffer(flaw, wrap, $urandom_range(1, 33), 0);
                else
                    add_buffer(flaw, wrap, 0, $urandom_range(20, 45));
            end
            drain_and_check();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/aphp_pkg.sv
hw/rtl/aphp_in_stage.sv
hw/rtl/aphp_parser.sv
hw/rtl/aphp_out_stage.sv
hw/rtl/apv_header_probe_top.sv
hw/rtl/aphp_checker.sv
sim/tb_apv_header_probe_top.sv
